>>> rtl/core/two_pool_bitmap_slot_allocator_defines.svh
// Assertion macros for the two-pool bitmap slot allocator.
// Depends on a clock named clock and a synchronous reset named reset.
`ifndef TWO_POOL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define TWO_POOL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define TPBSA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpbsa assertion failed");

// next-cycle implication
`define TPBSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpbsa assertion failed");

`endif

>>> rtl/core/tpbsa_pkg.sv
// Shared constants, action codes and controller command type for the
// two-pool bitmap slot allocator. No dependencies.
package tpbsa_pkg;

   localparam int SMALL_SLOTS_DEF = 32;
   localparam int LARGE_SLOTS_DEF = 32;
   localparam int ACTION_W        = 2;
   localparam int SLOT_W          = 6;

   localparam logic [ACTION_W-1:0] ACT_ALLOC_SMALL = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC_LARGE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE_SMALL  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_FREE_LARGE  = 2'd3;

   typedef struct packed {
      logic capture;  // latch the request transfer
      logic commit;   // update maps and load the result register
   } tpbsa_cmd_type;

endpackage

>>> rtl/core/two_pool_bitmap_slot_allocator.sv
// Two-pool bitmap slot allocator, top level. A request transfer is captured in the
// request register; the controller's commit step then updates the maps and loads
// the result register, and waits while an earlier result is not yet accepted. A new
// request is taken once the previous one has committed, also while an earlier
// result still waits. Synchronous reset frees every slot in both pools and drops
// the result valid. Depends on tpbsa_pkg, tpbsa_ctrl, tpbsa_datapath and the macros.
`include "two_pool_bitmap_slot_allocator_defines.svh"

module two_pool_bitmap_slot_allocator #(
   parameter int SMALL_SLOTS = tpbsa_pkg::SMALL_SLOTS_DEF,
   parameter int LARGE_SLOTS = tpbsa_pkg::LARGE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [5:0] slot_index, [7:6] zero
   input  logic [1:0] req_tuser,   // [1:0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] success, [6:1] granted_slot, [7] uses_pair
);
   import tpbsa_pkg::*;

   tpbsa_cmd_type     cmd;
   logic              success;
   logic [SLOT_W-1:0] granted_slot;
   logic              uses_pair;
   logic              pair_in_small;

   tpbsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tpbsa_datapath #(
      .SMALL_SLOTS (SMALL_SLOTS),
      .LARGE_SLOTS (LARGE_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_tuser),
      .req_slot_index   (req_tdata[SLOT_W-1:0]),
      .rsp_success      (success),
      .rsp_granted_slot (granted_slot),
      .rsp_uses_pair    (uses_pair)
   );

   assign rsp_tdata     = {uses_pair, granted_slot, success};
   assign pair_in_small = {1'b0, granted_slot} < 7'(SMALL_SLOTS);

   `TPBSA_ASSERT_NOW(a_fail_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[7:1] == 7'd0)
   `TPBSA_ASSERT_NOW(a_pair_small, rsp_tvalid && rsp_tdata[7], rsp_tdata[0] && pair_in_small)
   `TPBSA_ASSERT_NEXT(a_busy_after_take, req_tvalid && req_tready, !req_tready)

endmodule

>>> rtl/core/tpbsa_ctrl.sv
// Controller for the slot allocator: request/execute sequencing and the
// result valid flag. Depends on tpbsa_pkg.
module tpbsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output tpbsa_pkg::tpbsa_cmd_type cmd
);
   import tpbsa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.capture = req_tvalid && req_tready;
      cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

      case (state_ff)
         ST_IDLE: begin
            state_in = cmd.capture ? ST_EXEC : ST_IDLE;
         end
         ST_EXEC: begin
            state_in = cmd.commit ? ST_IDLE : ST_EXEC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/tpbsa_datapath.sv
// Datapath for the slot allocator: request register, both occupancy maps,
// lowest-free and lowest-free-pair encoders, result register. Depends on tpbsa_pkg.
module tpbsa_datapath #(
   parameter int SMALL_SLOTS = tpbsa_pkg::SMALL_SLOTS_DEF,
   parameter int LARGE_SLOTS = tpbsa_pkg::LARGE_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tpbsa_pkg::tpbsa_cmd_type          cmd,
   input  logic [tpbsa_pkg::ACTION_W-1:0]    req_action,
   input  logic [tpbsa_pkg::SLOT_W-1:0]      req_slot_index,
   output logic                              rsp_success,
   output logic [tpbsa_pkg::SLOT_W-1:0]      rsp_granted_slot,
   output logic                              rsp_uses_pair
);
   import tpbsa_pkg::*;

   logic [ACTION_W-1:0]    action_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [SMALL_SLOTS-1:0] small_ff, small_in;
   logic [LARGE_SLOTS-1:0] large_ff, large_in;
   logic                   success_ff, success_in;
   logic [SLOT_W-1:0]      granted_ff, granted_in;
   logic                   pair_ff, pair_in;

   logic [SMALL_SLOTS-1:0] s_free, s_one, s_clr;
   logic [LARGE_SLOTS-1:0] l_free, l_one, l_clr;
   logic [SMALL_SLOTS-2:0] p_cand, p_one;
   logic [SLOT_W-1:0]      s_loc, l_loc, p_loc, l_grant;
   logic [SLOT_W:0]        l_sum, slot_ext, slot_nx, l_off;
   logic                   in_large;

   // lowest free slot and lowest free adjacent pair
   always_comb begin
      s_free = ~small_ff;
      s_one  = s_free & (~s_free + SMALL_SLOTS'(1));
      l_free = ~large_ff;
      l_one  = l_free & (~l_free + LARGE_SLOTS'(1));
      for (int i = 0; i < SMALL_SLOTS - 1; i++) begin
         p_cand[i] = s_free[i] & s_free[i+1];
      end
      p_one = p_cand & (~p_cand + (SMALL_SLOTS-1)'(1));

      s_loc = '0;
      p_loc = '0;
      l_loc = '0;
      for (int i = 0; i < SMALL_SLOTS; i++) begin
         if (s_one[i]) begin
            s_loc = s_loc | SLOT_W'(i);
         end
      end
      for (int i = 0; i < SMALL_SLOTS - 1; i++) begin
         if (p_one[i]) begin
            p_loc = p_loc | SLOT_W'(i);
         end
      end
      for (int j = 0; j < LARGE_SLOTS; j++) begin
         if (l_one[j]) begin
            l_loc = l_loc | SLOT_W'(j);
         end
      end
      l_sum   = (SLOT_W+1)'(SMALL_SLOTS) + {1'b0, l_loc};
      l_grant = l_sum[SLOT_W-1:0];
   end

   // clear masks for frees
   always_comb begin
      slot_ext = {1'b0, slot_ff};
      slot_nx  = slot_ext + (SLOT_W+1)'(1);
      in_large = slot_ext >= (SLOT_W+1)'(SMALL_SLOTS);
      l_off    = slot_ext - (SLOT_W+1)'(SMALL_SLOTS);
      for (int i = 0; i < SMALL_SLOTS; i++) begin
         s_clr[i] = (slot_ext == (SLOT_W+1)'(i)) ||
                    ((action_ff == ACT_FREE_LARGE) && (slot_nx == (SLOT_W+1)'(i)));
      end
      for (int j = 0; j < LARGE_SLOTS; j++) begin
         l_clr[j] = in_large && (l_off == (SLOT_W+1)'(j));
      end
   end

   always_comb begin
      small_in   = small_ff;
      large_in   = large_ff;
      success_in = 1'b1;
      granted_in = '0;
      pair_in    = 1'b0;
      case (action_ff)
         ACT_ALLOC_SMALL: begin
            if (|s_free) begin
               small_in   = small_ff | s_one;
               granted_in = s_loc;
            end else if (|l_free) begin
               large_in   = large_ff | l_one;
               granted_in = l_grant;
            end else begin
               success_in = 1'b0;
            end
         end
         ACT_ALLOC_LARGE: begin
            if (|l_free) begin
               large_in   = large_ff | l_one;
               granted_in = l_grant;
            end else if (|p_cand) begin
               small_in   = small_ff | {1'b0, p_one} | {p_one, 1'b0};
               granted_in = p_loc;
               pair_in    = 1'b1;
            end else begin
               success_in = 1'b0;
            end
         end
         default: begin
            small_in = small_ff & ~s_clr;
            large_in = large_ff & ~l_clr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         slot_ff   <= req_slot_index;
      end
      if (cmd.commit) begin
         success_ff <= success_in;
         granted_ff <= granted_in;
         pair_ff    <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_ff <= '0;
         large_ff <= '0;
      end else if (cmd.commit) begin
         small_ff <= small_in;
         large_ff <= large_in;
      end
   end

   assign rsp_success      = success_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_uses_pair    = pair_ff;

endmodule
